// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	`ASSERT_CLK(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/ljpr_pkg.sv =====
`default_nettype none

package ljpr_pkg;

	localparam int MAX_WIDTH      = 4096;
	localparam int MAX_COMPONENTS = 4;

	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int COMP_W      = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
	localparam int STORE_DEPTH = MAX_WIDTH * MAX_COMPONENTS;
	localparam int IDX_W       = $clog2(STORE_DEPTH);

	localparam int SAMPLE_W   = 16;
	localparam int DIFF_W     = 17;
	localparam int PRED_W     = 3;
	localparam int PREC_W     = 5;
	localparam int PT_W       = 4;
	localparam int RWIDTH_W   = 13;
	localparam int NCOMP_W    = 3;
	localparam int RESTART_W  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PREDICTOR  = 3'd0,
		REG_PRECISION  = 3'd1,
		REG_POINT_XFRM = 3'd2,
		REG_ROW_WIDTH  = 3'd3,
		REG_NUM_COMP   = 3'd4,
		REG_RESTART    = 3'd5
	} cfg_reg_t;

	// a = left, b = above, c = above-left
	typedef enum logic [PRED_W-1:0] {
		PRED_NONE   = 3'd0,
		PRED_A      = 3'd1,
		PRED_B      = 3'd2,
		PRED_C      = 3'd3,
		PRED_ABC    = 3'd4,
		PRED_A_HALF = 3'd5,
		PRED_B_HALF = 3'd6,
		PRED_AVG    = 3'd7
	} pred_t;

endpackage

`default_nettype wire

// ===== rtl/lossless_jpeg_predictor_reconstruct.sv =====
// Lossless JPEG predictor reconstruction, one sample per difference.
// A transferred difference is registered into stage 1, and its sample into the output
// register, from which it transfers out.
// Throughput: one transfer per cycle while the output is not stalled; the left-sample loop
// closes in stage 1, and the previous-row store takes one read and one write per cycle.
// Reset (arst_n low, async): config to defaults, counters cleared, first-row mode, pipe empty.
`default_nettype none

module lossless_jpeg_predictor_reconstruct import ljpr_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         cfg_write,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data,
	// difference stream in
	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic signed [DIFF_W-1:0]     difference,
	input  wire logic                         scan_start,
	// sample stream out
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic [SAMPLE_W-1:0]          sample,
	output      logic [1:0]                   component,
	output      logic                         row_end
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	pred_t                 pred_sel_q;
	logic [PREC_W-1:0]     precision_q;
	logic [PT_W-1:0]       point_xfrm_q;
	logic [RWIDTH_W-1:0]   row_width_q;
	logic [NCOMP_W-1:0]    num_comp_q;
	logic [RESTART_W-1:0]  restart_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_sel_q     <= PRED_A;
			precision_q    <= PREC_W'(8);
			point_xfrm_q   <= '0;
			row_width_q    <= RWIDTH_W'(1);
			num_comp_q     <= NCOMP_W'(1);
			restart_rows_q <= '0;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_PREDICTOR:  pred_sel_q     <= pred_t'(cfg_data[PRED_W-1:0]);
				REG_PRECISION:  precision_q    <= cfg_data[PREC_W-1:0];
				REG_POINT_XFRM: point_xfrm_q   <= cfg_data[PT_W-1:0];
				REG_ROW_WIDTH:  row_width_q    <= cfg_data[RWIDTH_W-1:0];
				REG_NUM_COMP:   num_comp_q     <= cfg_data[NCOMP_W-1:0];
				REG_RESTART:    restart_rows_q <= cfg_data[RESTART_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage 0: position tracking and store read
	// Counters depend only on the shape, never on sample data, so they
	// advance right at the transfer and the store read issues then too.
	// ------------------------------------------------------------------
	logic [COL_W-1:0]      col_q;
	logic [COMP_W-1:0]     comp_q;
	logic [RESTART_W-1:0]  rows_left_q;
	logic                  first_row_q;

	logic                  accept;
	logic [COL_W:0]        eff_width;
	logic [COMP_W:0]       eff_ncomp;
	logic [COL_W-1:0]      col_base, col0, col_n;
	logic [COMP_W-1:0]     comp_base, comp0, comp_n;
	logic [RESTART_W-1:0]  rows_base, rows_n;
	logic                  first_base, first_n;
	logic                  last_comp, last_col;
	logic [IDX_W-1:0]      idx0;

	assign accept = in_valid && !in_stall;

	always_comb begin
		// clamp shape to what the store can hold
		if (row_width_q == '0) begin
			eff_width = (COL_W+1)'(1);
		end else if (int'(row_width_q) > MAX_WIDTH) begin
			eff_width = (COL_W+1)'(MAX_WIDTH);
		end else begin
			eff_width = (COL_W+1)'(row_width_q);
		end
		if (num_comp_q == '0) begin
			eff_ncomp = (COMP_W+1)'(1);
		end else if (int'(num_comp_q) > MAX_COMPONENTS) begin
			eff_ncomp = (COMP_W+1)'(MAX_COMPONENTS);
		end else begin
			eff_ncomp = (COMP_W+1)'(num_comp_q);
		end

		// new scan restarts position and first-row mode
		if (scan_start) begin
			col_base   = '0;
			comp_base  = '0;
			first_base = 1'b1;
			rows_base  = '0;
		end else begin
			col_base   = col_q;
			comp_base  = comp_q;
			first_base = first_row_q;
			rows_base  = rows_left_q;
		end

		// a position left beyond a shrunken shape sticks to the last slot
		col0  = ({1'b0, col_base} >= eff_width) ? COL_W'(eff_width - 1'b1) : col_base;
		comp0 = ({1'b0, comp_base} >= eff_ncomp) ? COMP_W'(eff_ncomp - 1'b1) : comp_base;

		last_comp = ({1'b0, comp0} + 1'b1) >= eff_ncomp;
		last_col  = ({1'b0, col0} + 1'b1) >= eff_width;

		idx0 = IDX_W'(int'(col0) * MAX_COMPONENTS + int'(comp0));

		col_n   = col0;
		comp_n  = comp0;
		first_n = first_base;
		rows_n  = rows_base;
		if (!last_comp) begin
			comp_n = comp0 + 1'b1;
		end else if (!last_col) begin
			col_n  = col0 + 1'b1;
			comp_n = '0;
		end else begin
			// end of row: restart interval bookkeeping
			col_n  = '0;
			comp_n = '0;
			if (restart_rows_q == '0) begin
				first_n = 1'b0;
			end else if (first_base) begin
				rows_n  = restart_rows_q - 1'b1;
				first_n = (restart_rows_q == RESTART_W'(1));
			end else begin
				// a lost count (zero outside a first row) just starts a new interval
				rows_n  = (rows_base != '0) ? rows_base - 1'b1 : rows_base;
				first_n = (rows_n == '0);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			comp_q      <= '0;
			rows_left_q <= '0;
			first_row_q <= 1'b1;
		end else if (accept) begin
			col_q       <= col_n;
			comp_q      <= comp_n;
			rows_left_q <= rows_n;
			first_row_q <= first_n;
		end
	end

	// ------------------------------------------------------------------
	// Previous-row store
	// ------------------------------------------------------------------
	logic                  valid_s1;
	logic [IDX_W-1:0]      idx_s1;
	logic [COMP_W-1:0]     comp_s1;
	logic                  col_zero_s1;
	logic                  first_s1;
	logic                  row_end_s1;
	logic [SAMPLE_W-1:0]   diff_s1;
	logic                  fwd_s1;
	logic [SAMPLE_W-1:0]   fwd_data_s1;

	logic                  advance;
	logic                  store_we;
	logic [SAMPLE_W-1:0]   store_rdata;
	logic [SAMPLE_W-1:0]   sample_s1;

	// the stage-1 sample retires into the store as it moves to the output
	assign store_we = advance;

	ljpr_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (idx_s1),
		.wdata (sample_s1),
		.re    (accept),
		.raddr (idx0),
		.rdata (store_rdata)
	);

	// ------------------------------------------------------------------
	// Stage 1: prediction and reconstruction
	// ------------------------------------------------------------------
	logic [SAMPLE_W-1:0]   left_q [MAX_COMPONENTS];
	logic [SAMPLE_W-1:0]   upleft_q [MAX_COMPONENTS];

	logic                  out_valid_q;
	logic [SAMPLE_W-1:0]   sample_q;
	logic [1:0]            component_q;
	logic                  row_end_q;

	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// A read that meets the write to the same entry on one edge gets the
	// old word from the RAM, so the new sample is forwarded. Happens when
	// a row holds a single slot, or a scan start follows the first slot.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1      <= idx0;
			comp_s1     <= comp0;
			col_zero_s1 <= (col0 == '0);
			first_s1    <= first_base;
			row_end_s1  <= last_comp && last_col;
			diff_s1     <= difference[SAMPLE_W-1:0];
			fwd_s1      <= store_we && (idx_s1 == idx0);
			fwd_data_s1 <= sample_s1;
		end
	end

	logic [SAMPLE_W-1:0]   a_val, b_val, c_val;
	logic signed [SAMPLE_W+1:0] sa, sb, sc, pmix;
	logic [PREC_W-1:0]     init_exp;
	logic [SAMPLE_W-1:0]   init_val;
	logic [SAMPLE_W-1:0]   pred;

	always_comb begin
		a_val = left_q[comp_s1];
		b_val = fwd_s1 ? fwd_data_s1 : store_rdata;
		c_val = upleft_q[comp_s1];

		sa = $signed({2'b00, a_val});
		sb = $signed({2'b00, b_val});
		sc = $signed({2'b00, c_val});

		// arithmetic shifts give the floor of the halved differences and sums
		case (pred_sel_q)
			PRED_NONE:   pmix = '0;
			PRED_A:      pmix = sa;
			PRED_B:      pmix = sb;
			PRED_C:      pmix = sc;
			PRED_ABC:    pmix = sa + sb - sc;
			PRED_A_HALF: pmix = sa + ((sb - sc) >>> 1);
			PRED_B_HALF: pmix = sb + ((sa - sc) >>> 1);
			PRED_AVG:    pmix = (sa + sb) >>> 1;
			default:     pmix = sa;
		endcase

		// initial value 2^(P-Pt-1); zero when Pt >= P or when it wraps out of 16 bits
		init_exp = precision_q - PREC_W'(point_xfrm_q) - 1'b1;
		if (PREC_W'(point_xfrm_q) >= precision_q) begin
			init_val = '0;
		end else if (int'(init_exp) >= SAMPLE_W) begin
			init_val = '0;
		end else begin
			init_val = SAMPLE_W'(1) << init_exp;
		end

		if (first_s1) begin
			pred = col_zero_s1 ? init_val : a_val;
		end else if (col_zero_s1) begin
			pred = b_val;
		end else begin
			pred = pmix[SAMPLE_W-1:0];
		end

		sample_s1 = pred + diff_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_COMPONENTS; i++) begin
				left_q[i]   <= '0;
				upleft_q[i] <= '0;
			end
		end else if (advance) begin
			left_q[comp_s1]   <= sample_s1;
			upleft_q[comp_s1] <= b_val;
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sample_q    <= sample_s1;
			component_q <= 2'(comp_s1);
			row_end_q   <= row_end_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign sample    = sample_q;
	assign component = component_q;
	assign row_end   = row_end_q;

endmodule

`default_nettype wire

// ===== rtl/ljpr_ram.sv =====
`default_nettype none

module ljpr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-during-write to one address returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ljpr_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module ljpr_props import ljpr_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire logic [SAMPLE_W-1:0] sample,
	input wire logic [1:0]          component,
	input wire logic                row_end
);

	logic       in_xfer, out_xfer;
	logic [1:0] inflight_q;
	logic       after_row_end_q;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q      <= '0;
			after_row_end_q <= 1'b0;
		end else begin
			inflight_q <= inflight_q + 2'(in_xfer) - 2'(out_xfer);
			if (out_xfer) begin
				after_row_end_q <= row_end;
			end
		end
	end

	// stalled output holds its payload
	`ASSERT_CLK(a_out_hold, clk, arst_n,
		out_valid && out_stall |=> out_valid && $stable(sample) && $stable(component)
		&& $stable(row_end), "output changed while stalled")

	// input backs up only behind a full, stalled output register
	`ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall,
		"input stalled without output backpressure")

	// no result without a transfer in, and at most two items held
	`ASSERT_IMPL(a_no_invent, clk, arst_n, out_valid, inflight_q != 2'd0,
		"result with nothing in flight")
	`ASSERT_CLK(a_depth, clk, arst_n, inflight_q != 2'd3, "more than two items in flight")

	// a new row always opens with the first component
	`ASSERT_IMPL(a_row_start, clk, arst_n, out_valid && after_row_end_q, component == 2'd0,
		"row did not start at component 0")

endmodule

bind lossless_jpeg_predictor_reconstruct ljpr_props u_ljpr_checker (.*);

`default_nettype wire
